>>> hw/rtl/fqr_pkg.sv
// Shared constants, codes and types for the positional-removal queue.
`default_nettype none

package fqr_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 32;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;

    // Request codes.
    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_READ   = 3'd3;
    localparam logic [2:0] REQ_FIND   = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Per-cell update command.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/fqr_cell.sv
// One storage cell of the queue: holds an entry, shifts toward the head, compares.
`default_nettype none

module fqr_cell (
    input  wire logic                           clk,
    input  wire fqr_pkg::cell_ctrl_t            ctrl,
    input  wire logic [fqr_pkg::ID_WIDTH-1:0]   new_id,
    input  wire logic [fqr_pkg::ID_WIDTH-1:0]   next_data,
    output logic      [fqr_pkg::ID_WIDTH-1:0]   data,
    output logic                                match
);

    logic [fqr_pkg::ID_WIDTH-1:0] data_reg;
    logic [fqr_pkg::ID_WIDTH-1:0] data_next;

    // Shift takes the neighbor's entry; load takes the pushed identifier.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = next_data;
        end
        else if (ctrl.load)
        begin
            data_next = new_id;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Local compare against the searched identifier.
    assign data  = data_reg;
    assign match = (data_reg == new_id);

endmodule

`default_nettype wire

>>> hw/rtl/fifo_queue_with_positional_removal_core.sv
// Top level of the queue: a row of shifting cells plus count and result logic.
// Latency: a result beat appears on done in the cycle after its request is taken.
// Throughput: one request per cycle; busy stays low, as every request finishes
// with the cell row update and its compare.
// Reset: rst_n clears the entry count and the done strobe; cell contents are
// left as they are and are never read before being written.
`default_nettype none

module fifo_queue_with_positional_removal_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [2:0]                           req_type,
    input  wire logic [fqr_pkg::ID_WIDTH-1:0]         entry_id,
    input  wire logic [fqr_pkg::IDX_W-1:0]            position,
    output logic                                      done,
    output logic      [fqr_pkg::ID_WIDTH-1:0]         result_id,
    output logic      [fqr_pkg::CNT_W-1:0]            result_position,
    output logic      [1:0]                           status,
    output logic      [fqr_pkg::CNT_W-1:0]            count,
    output logic                                      is_empty_flag
);

    localparam int DEPTH = fqr_pkg::QUEUE_DEPTH;
    localparam int IDW   = fqr_pkg::ID_WIDTH;
    localparam int CW    = fqr_pkg::CNT_W;
    localparam int IW    = fqr_pkg::IDX_W;

    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic                  done_reg;
    logic [IDW-1:0]        rid_reg;
    logic [IDW-1:0]        rid_next;
    logic [CW-1:0]         rpos_reg;
    logic [CW-1:0]         rpos_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;

    logic [IDW-1:0]        cell_data [DEPTH];
    logic [DEPTH-1:0]      cell_match;
    fqr_pkg::cell_ctrl_t   cell_ctrl [DEPTH];

    logic                  accept;
    logic                  push_ok;
    logic                  take_ok;
    logic [IW-1:0]         take_pos;
    logic [IDW-1:0]        rd_data;
    logic                  found;
    logic [CW-1:0]         found_idx;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Row of cells; the last one shifts in zero.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [IDW-1:0] nbr;
        if (g == DEPTH - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_data[g+1];
        end

        fqr_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[g]),
            .new_id    (entry_id),
            .next_data (nbr),
            .data      (cell_data[g]),
            .match     (cell_match[g])
        );
    end

    // Read port: the head for pop, the requested position otherwise.
    assign take_pos = (req_type == fqr_pkg::REQ_POP) ? '0 : position;
    assign rd_data  = cell_data[take_pos];

    // First valid matching cell.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (cell_match[i] && (CW'(i) < cnt_reg))
            begin
                found     = 1'b1;
                found_idx = CW'(i);
            end
        end
    end

    // Request decode and result selection.
    always_comb
    begin
        push_ok     = 1'b0;
        take_ok     = 1'b0;
        rid_next    = '0;
        rpos_next   = '0;
        status_next = fqr_pkg::ST_OK;
        unique case (req_type) inside
            fqr_pkg::REQ_PUSH:
            begin
                if (cnt_reg == CW'(DEPTH))
                begin
                    status_next = fqr_pkg::ST_FULL;
                end
                else
                begin
                    push_ok = 1'b1;
                end
            end
            fqr_pkg::REQ_POP,
            fqr_pkg::REQ_REMOVE,
            fqr_pkg::REQ_READ:
            begin
                if ({1'b0, take_pos} < cnt_reg)
                begin
                    rid_next = rd_data;
                    take_ok  = (req_type != fqr_pkg::REQ_READ);
                end
                else
                begin
                    status_next = fqr_pkg::ST_RANGE;
                end
            end
            fqr_pkg::REQ_FIND:
            begin
                if (found)
                begin
                    rpos_next = found_idx;
                end
                else
                begin
                    rpos_next   = cnt_reg;
                    status_next = fqr_pkg::ST_NOTFOUND;
                end
            end
            default:
            begin
                status_next = fqr_pkg::ST_RANGE;
            end
        endcase
    end

    // Per-cell commands: shift closes the gap, load appends at the tail.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_ctrl[i].shift = accept & take_ok & (CW'(i) >= {1'b0, take_pos})
                                 & ((CW'(i) + CW'(1)) < cnt_reg);
            cell_ctrl[i].load  = accept & push_ok & (CW'(i) == cnt_reg);
        end
    end

    // Entry count update.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && push_ok)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (accept && take_ok)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= accept;
        end
    end

    // Result beat payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rid_reg    <= rid_next;
            rpos_reg   <= rpos_next;
            status_reg <= status_next;
        end
    end

    assign done            = done_reg;
    assign result_id       = rid_reg;
    assign result_position = rpos_reg;
    assign status          = status_reg;
    assign count           = cnt_reg;
    assign is_empty_flag   = (cnt_reg == '0);

endmodule

`default_nettype wire

>>> hw/rtl/fqr_checker.sv
// Port-level checks on the queue core, bound to the top level.
`default_nettype none

module fqr_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                done,
    input wire logic [fqr_pkg::CNT_W-1:0]           result_position,
    input wire logic [1:0]                          status,
    input wire logic [fqr_pkg::CNT_W-1:0]           count,
    input wire logic                                is_empty_flag
);

    // Every taken request yields a result beat in the next cycle.
    a_req_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("request without result beat");

    // No result beat without a request in the cycle before.
    a_done_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result beat without request");

    // A rejected push leaves the queue full.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fqr_pkg::ST_FULL) |-> (count == fqr_pkg::CNT_W'(fqr_pkg::QUEUE_DEPTH)))
        else $error("full status with room left");

    // A failed search reports the count as its position, and empty tracks count.
    a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status != fqr_pkg::ST_NOTFOUND || result_position == count)
                  && (is_empty_flag == (count == '0))))
        else $error("search position or empty flag mismatch");

endmodule

bind fifo_queue_with_positional_removal_core fqr_checker u_fqr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .result_position (result_position),
    .status          (status),
    .count           (count),
    .is_empty_flag   (is_empty_flag)
);

`default_nettype wire
